### src/lrg_pkg.sv
// Package for the lidar return gate: default sizes, register map, reset values,
// sine polynomial coefficients and the controller state type.
// Used by lidar_return_gate_sector_min, lrg_sine and the testbench; depends on nothing.
package lrg_pkg;

    localparam int MAX_SECTORS_DEF = 16;
    localparam int RANGE_BITS_DEF  = 20;
    localparam int ANGLE_BITS_DEF  = 16;

    localparam logic [31:0] SIN_KA = 32'd1686632582;
    localparam logic [31:0] SIN_KB = 32'd691032320;
    localparam logic [31:0] SIN_KC = 32'd78141562;

    localparam logic [1:0] REG_MIN_RANGE   = 2'd0;
    localparam logic [1:0] REG_MAX_RANGE   = 2'd1;
    localparam logic [1:0] REG_FILTER_SELF = 2'd2;
    localparam logic [1:0] REG_SECTORS     = 2'd3;

    localparam int MIN_RANGE_RST   = 100;
    localparam int MAX_RANGE_RST   = 40000;
    localparam int SECTORS_RST     = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRIG,
        ST_MUL,
        ST_PT_OUT,
        ST_DUMP_RD,
        ST_DUMP_OUT
    } lrg_state_t;

endpackage

### src/lidar_return_gate_sector_min.sv
// Lidar return gate with Cartesian conversion, frame minimum and sector minima.
// Instantiates lrg_sine and lrg_secmem; uses lrg_pkg.
//
// A kept return is accepted, then takes four sine evaluations on the shared sine unit (four
// steps and a done strobe each), then five fixed-point products on one multiplier, then the
// load of the output register. A stalled output holds the block in that last state. A dropped
// return leaves the block idle. A frame end is accepted; each report then takes a registered
// read of the sector memory and a load of the output register, and the block emits
// max(1, sectors in use) reports. The block takes no input while it walks the sectors.
// The sector valid flags clear at once with the last report, so no clearing pass follows
// reset.
module lidar_return_gate_sector_min #(
    parameter int MAX_SECTORS = lrg_pkg::MAX_SECTORS_DEF,
    parameter int RANGE_BITS  = lrg_pkg::RANGE_BITS_DEF,
    parameter int ANGLE_BITS  = lrg_pkg::ANGLE_BITS_DEF,
    localparam int IN_W  = (((2 * ANGLE_BITS + RANGE_BITS + 2) + 7) / 8) * 8,
    localparam int OUT_W = (((5 * RANGE_BITS + 41) + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // azimuth, elevation, range, hit, self_hit
    input  logic [IN_W-1:0]  s_tdata,
    // opcode
    input  logic             s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // pos_x, pos_y, pos_z, sector_index, sector_min, sector_seen,
    // frame_min, frame_seen, point_count, frame_number
    output logic [OUT_W-1:0] m_tdata,
    // kind
    output logic             m_tuser,
    output logic             m_tlast,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import lrg_pkg::*;

    localparam int AB    = ANGLE_BITS;
    localparam int RB    = RANGE_BITS;
    localparam int PW    = RB + 1;
    localparam int SEC_W = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
    localparam int N_W   = $clog2(MAX_SECTORS + 1);
    localparam int OPW   = (RB > 21) ? RB : 21;
    localparam int PRW   = 2 * OPW;
    localparam logic [AB-1:0] QTURN = {2'b01, {(AB - 2){1'b0}}};

    lrg_state_t state_reg, state_next;

    logic [RB-1:0] min_range_reg, min_range_next;
    logic [RB-1:0] max_range_reg, max_range_next;
    logic          filter_self_reg, filter_self_next;
    logic [4:0]    sectors_reg, sectors_next;

    logic [1:0]     tidx_reg, tidx_next;
    logic [2:0]     midx_reg, midx_next;
    logic [N_W-1:0] k_reg, k_next;
    logic           fvalid_reg, fvalid_next;
    logic [RB-1:0]  fmin_reg, fmin_next;
    logic [15:0]    cnt_reg, cnt_next;
    logic [15:0]    frames_reg, frames_next;
    logic           m_tvalid_reg, m_tvalid_next;

    logic [AB-1:0]  az_reg, el_reg;
    logic [RB-1:0]  r_reg;
    logic           sec_upd_reg;
    logic [SEC_W-1:0] sec_addr_reg;
    logic [20:0]    ce_reg, se_reg, ca_reg, sa_reg, fx_reg, fy_reg;
    logic           nce_reg, nse_reg, nca_reg, nsa_reg;
    logic [PW-1:0]  xm_reg, ym_reg, zm_reg;
    logic [N_W-1:0] rep_last_reg;
    logic           rep_en_reg;
    logic [RB-1:0]  rep_fmin_reg;
    logic           rep_fseen_reg;
    logic [15:0]    rep_cnt_reg, rep_fnum_reg;
    logic [OUT_W-1:0] m_tdata_reg;
    logic           m_tuser_reg, m_tlast_reg;

    logic [AB-1:0]  in_az, in_el_u;
    logic signed [AB-1:0] in_el;
    logic [RB-1:0]  in_rng;
    logic           in_hit, in_self;
    logic           s_acc, out_free, keep, cfg_wr;
    logic [1:0]     reg_idx;
    logic [N_W-1:0] n_cur;
    logic [AB+N_W-1:0] sprod;
    logic [N_W-1:0] s_raw, s_clamp;

    logic           sin_start, sin_done, sin_neg;
    logic [AB-1:0]  sin_phase;
    logic [20:0]    sin_mag;

    logic           mem_rd_en, mem_wr_en, mem_clear, mem_rd_valid;
    logic [SEC_W-1:0] mem_rd_addr;
    logic [RB-1:0]  mem_rd_data;

    logic [OPW-1:0] mul_a, mul_b;
    logic [PRW-1:0] qsum;
    logic           load_pt, load_rep;

    assign in_az   = s_tdata[AB-1:0];
    assign in_el   = s_tdata[2*AB-1:AB];
    assign in_el_u = in_el;
    assign in_rng  = s_tdata[2*AB+RB-1:2*AB];
    assign in_hit  = s_tdata[2*AB+RB];
    assign in_self = s_tdata[2*AB+RB+1];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign keep     = in_hit && !(filter_self_reg && in_self)
                      && !(in_rng < min_range_reg) && !(in_rng > max_range_reg);

    assign n_cur   = (32'(sectors_reg) > MAX_SECTORS) ? N_W'(MAX_SECTORS)
                                                     : N_W'(sectors_reg);
    assign sprod   = (AB + N_W)'(in_az) * (AB + N_W)'(n_cur);
    assign s_raw   = sprod[AB+N_W-1:AB];
    assign s_clamp = (n_cur != '0 && s_raw > n_cur - N_W'(1)) ? n_cur - N_W'(1) : s_raw;

    // Configuration port.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb begin
        min_range_next   = min_range_reg;
        max_range_next   = max_range_reg;
        filter_self_next = filter_self_reg;
        sectors_next     = sectors_reg;
        if (cfg_wr) begin
            case (reg_idx)
                REG_MIN_RANGE: begin
                    min_range_next = pwdata[RB-1:0];
                end
                REG_MAX_RANGE: begin
                    max_range_next = pwdata[RB-1:0];
                end
                REG_FILTER_SELF: begin
                    filter_self_next = pwdata[0];
                end
                REG_SECTORS: begin
                    sectors_next = pwdata[4:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MIN_RANGE:   prdata = 32'(min_range_reg);
            REG_MAX_RANGE:   prdata = 32'(max_range_reg);
            REG_FILTER_SELF: prdata = 32'(filter_self_reg);
            REG_SECTORS:     prdata = 32'(sectors_reg);
            default:         prdata = 32'd0;
        endcase
    end

    function automatic logic [AB-1:0] phase_of(input logic [1:0] idx,
                                               input logic [AB-1:0] az,
                                               input logic [AB-1:0] el);
        logic [AB-1:0] p;
        case (idx)
            2'd0:    p = el + QTURN;
            2'd1:    p = el;
            2'd2:    p = az + QTURN;
            default: p = az;
        endcase
        return p;
    endfunction

    function automatic logic [PW-1:0] signed_out(input logic [PW-1:0] m,
                                                 input logic n);
        logic [PW-1:0] lim;
        logic [PW-1:0] v;
        lim = {1'b1, {RB{1'b0}}};
        if (n) begin
            v = (m > lim) ? lim : m;
            v = ~v + PW'(1);
        end else begin
            v = (m > lim - PW'(1)) ? lim - PW'(1) : m;
        end
        return v;
    endfunction

    lrg_sine #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_sine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sin_start),
        .phase   (sin_phase),
        .done    (sin_done),
        .mag     (sin_mag),
        .neg     (sin_neg)
    );

    lrg_secmem #(
        .DEPTH(MAX_SECTORS),
        .AW   (SEC_W),
        .DW   (RB)
    ) u_secmem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (mem_rd_en),
        .rd_addr   (mem_rd_addr),
        .rd_data   (mem_rd_data),
        .rd_valid  (mem_rd_valid),
        .wr_en     (mem_wr_en),
        .wr_addr   (sec_addr_reg),
        .wr_data   (r_reg),
        .clear_all (mem_clear)
    );

    // Shared Q20 multiplier with round-half-up.
    always_comb begin
        case (midx_reg)
            3'd0: begin
                mul_a = OPW'(ce_reg);
                mul_b = OPW'(ca_reg);
            end
            3'd1: begin
                mul_a = OPW'(ce_reg);
                mul_b = OPW'(sa_reg);
            end
            3'd2: begin
                mul_a = OPW'(r_reg);
                mul_b = OPW'(fx_reg);
            end
            3'd3: begin
                mul_a = OPW'(r_reg);
                mul_b = OPW'(fy_reg);
            end
            default: begin
                mul_a = OPW'(r_reg);
                mul_b = OPW'(se_reg);
            end
        endcase
    end

    assign qsum = PRW'(mul_a) * PRW'(mul_b) + (PRW'(1) << 19);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_tuser) begin
                        state_next = ST_DUMP_RD;
                    end else if (keep) begin
                        state_next = ST_TRIG;
                    end
                end
            end
            ST_TRIG: begin
                if (sin_done && tidx_reg == 2'd3) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (midx_reg == 3'd4) begin
                    state_next = ST_PT_OUT;
                end
            end
            ST_PT_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DUMP_RD: begin
                state_next = ST_DUMP_OUT;
            end
            ST_DUMP_OUT: begin
                if (out_free) begin
                    state_next = (k_reg == rep_last_reg) ? ST_IDLE : ST_DUMP_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        sin_start   = 1'b0;
        sin_phase   = phase_of(tidx_reg + 2'd1, az_reg, el_reg);
        mem_rd_en   = 1'b0;
        mem_rd_addr = s_clamp[SEC_W-1:0];
        mem_wr_en   = 1'b0;
        mem_clear   = 1'b0;
        load_pt     = 1'b0;
        load_rep    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                sin_phase = phase_of(2'd0, in_az, in_el_u);
                sin_start = s_acc && !s_tuser && keep;
                mem_rd_en = s_acc && !s_tuser && keep;
            end
            ST_TRIG: begin
                sin_start = sin_done && (tidx_reg != 2'd3);
            end
            ST_MUL: begin
                mem_wr_en = (midx_reg == 3'd0) && sec_upd_reg
                            && (!mem_rd_valid || r_reg < mem_rd_data);
            end
            ST_PT_OUT: begin
                load_pt = out_free;
            end
            ST_DUMP_RD: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = k_reg[SEC_W-1:0];
            end
            ST_DUMP_OUT: begin
                load_rep  = out_free;
                mem_clear = out_free && (k_reg == rep_last_reg);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        tidx_next     = tidx_reg;
        midx_next     = midx_reg;
        k_next        = k_reg;
        fvalid_next   = fvalid_reg;
        fmin_next     = fmin_reg;
        cnt_next      = cnt_reg;
        frames_next   = frames_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (load_pt || load_rep) begin
            m_tvalid_next = 1'b1;
        end
        if (state_reg == ST_IDLE && s_acc) begin
            tidx_next = 2'd0;
            midx_next = 3'd0;
            k_next    = '0;
            if (s_tuser) begin
                frames_next = frames_reg + 16'd1;
                fvalid_next = 1'b0;
                fmin_next   = '0;
                cnt_next    = 16'd0;
            end else if (keep) begin
                if (cnt_reg != 16'hFFFF) begin
                    cnt_next = cnt_reg + 16'd1;
                end
                if (!fvalid_reg || in_rng < fmin_reg) begin
                    fmin_next   = in_rng;
                    fvalid_next = 1'b1;
                end
            end
        end
        if (state_reg == ST_TRIG && sin_done) begin
            tidx_next = tidx_reg + 2'd1;
        end
        if (state_reg == ST_MUL) begin
            midx_next = midx_reg + 3'd1;
        end
        if (load_rep) begin
            k_next = k_reg + N_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            min_range_reg   <= RB'(MIN_RANGE_RST);
            max_range_reg   <= RB'(MAX_RANGE_RST);
            filter_self_reg <= 1'b1;
            sectors_reg     <= 5'(SECTORS_RST);
            tidx_reg        <= 2'd0;
            midx_reg        <= 3'd0;
            k_reg           <= '0;
            fvalid_reg      <= 1'b0;
            fmin_reg        <= '0;
            cnt_reg         <= 16'd0;
            frames_reg      <= 16'd0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            min_range_reg   <= min_range_next;
            max_range_reg   <= max_range_next;
            filter_self_reg <= filter_self_next;
            sectors_reg     <= sectors_next;
            tidx_reg        <= tidx_next;
            midx_reg        <= midx_next;
            k_reg           <= k_next;
            fvalid_reg      <= fvalid_next;
            fmin_reg        <= fmin_next;
            cnt_reg         <= cnt_next;
            frames_reg      <= frames_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_acc) begin
            az_reg       <= in_az;
            el_reg       <= in_el_u;
            r_reg        <= in_rng;
            sec_upd_reg  <= (n_cur != '0);
            sec_addr_reg <= s_clamp[SEC_W-1:0];
            rep_en_reg   <= (n_cur != '0);
            rep_last_reg <= (n_cur == '0) ? '0 : n_cur - N_W'(1);
            rep_fmin_reg <= fvalid_reg ? fmin_reg : '0;
            rep_fseen_reg <= fvalid_reg;
            rep_cnt_reg  <= cnt_reg;
            rep_fnum_reg <= frames_reg + 16'd1;
        end
        if (state_reg == ST_TRIG && sin_done) begin
            case (tidx_reg)
                2'd0: begin
                    ce_reg  <= sin_mag;
                    nce_reg <= sin_neg;
                end
                2'd1: begin
                    se_reg  <= sin_mag;
                    nse_reg <= sin_neg;
                end
                2'd2: begin
                    ca_reg  <= sin_mag;
                    nca_reg <= sin_neg;
                end
                default: begin
                    sa_reg  <= sin_mag;
                    nsa_reg <= sin_neg;
                end
            endcase
        end
        if (state_reg == ST_MUL) begin
            case (midx_reg)
                3'd0:    fx_reg <= qsum[40:20];
                3'd1:    fy_reg <= qsum[40:20];
                3'd2:    xm_reg <= qsum[20 +: PW];
                3'd3:    ym_reg <= qsum[20 +: PW];
                default: zm_reg <= qsum[20 +: PW];
            endcase
        end
        if (load_pt) begin
            m_tdata_reg <= OUT_W'({signed_out(zm_reg, nse_reg),
                                   signed_out(ym_reg, nce_reg != nsa_reg),
                                   signed_out(xm_reg, nce_reg != nca_reg)});
            m_tuser_reg <= 1'b0;
            m_tlast_reg <= 1'b0;
        end else if (load_rep) begin
            m_tdata_reg <= OUT_W'({rep_fnum_reg, rep_cnt_reg, rep_fseen_reg, rep_fmin_reg,
                                   rep_en_reg && mem_rd_valid,
                                   (rep_en_reg && mem_rd_valid) ? mem_rd_data : RB'(0),
                                   rep_en_reg ? 4'(k_reg) : 4'd0,
                                   {(3 * PW){1'b0}}});
            m_tuser_reg <= 1'b1;
            m_tlast_reg <= (k_reg == rep_last_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_last_is_report: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("last flag on a point result");

    a_point_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[OUT_W-1:3*PW] == '0)
        else $error("point result carries report fields");

    a_count_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_acc && s_tuser) |=> cnt_reg >= $past(cnt_reg))
        else $error("point count dropped without a frame end");

    a_dump_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tuser |=> !s_tready)
        else $error("input taken during sector walk");

endmodule

### src/lrg_sine.sv
// Iterative fixed-point sine magnitude: one multiplier, four steps per angle.
// Depends on lrg_pkg for the polynomial coefficients.
module lrg_sine #(
    parameter int ANGLE_BITS = lrg_pkg::ANGLE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [ANGLE_BITS-1:0] phase,
    output logic                  done,
    output logic [20:0]           mag,
    output logic                  neg
);
    import lrg_pkg::*;

    localparam int SH = 20 - ANGLE_BITS;

    logic        running_reg, running_next;
    logic        done_reg, done_next;
    logic [1:0]  step_reg, step_next;
    logic [18:0] t_reg;
    logic [18:0] t2_reg;
    logic [31:0] acc_reg;
    logic        half_reg;
    logic [20:0] mag_reg;
    logic        neg_reg;

    logic [17:0] t18;
    logic [18:0] t_start;
    logic [18:0] mul_a;
    logic [31:0] mul_b;
    logic [50:0] prod;
    logic [32:0] psh;
    logic [32:0] rnd;

    assign t18     = 18'(phase[ANGLE_BITS-3:0]) << SH;
    assign t_start = phase[ANGLE_BITS-2] ? (19'd262144 - {1'b0, t18}) : {1'b0, t18};

    always_comb begin
        mul_a = t_reg;
        mul_b = acc_reg;
        case (step_reg)
            2'd0: begin
                mul_b = 32'(t_reg);
            end
            2'd1: begin
                mul_a = t2_reg;
                mul_b = SIN_KC;
            end
            2'd2: begin
                mul_a = t2_reg;
            end
            default: begin
                mul_a = t_reg;
            end
        endcase
    end

    assign prod = 51'(mul_a) * 51'(mul_b);
    assign psh  = prod[50:18];
    assign rnd  = {1'b0, psh[31:0]} + 33'd512;

    always_comb begin
        running_next = running_reg;
        step_next    = step_reg;
        done_next    = 1'b0;
        if (running_reg) begin
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd3) begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
        end else if (start) begin
            running_next = 1'b1;
            step_next    = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            step_reg    <= 2'd0;
        end else begin
            running_reg <= running_next;
            done_reg    <= done_next;
            step_reg    <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!running_reg && start) begin
            t_reg    <= t_start;
            half_reg <= phase[ANGLE_BITS-1];
        end else if (running_reg) begin
            case (step_reg)
                2'd0: begin
                    t2_reg <= psh[18:0];
                end
                2'd1: begin
                    acc_reg <= SIN_KB - psh[31:0];
                end
                2'd2: begin
                    acc_reg <= SIN_KA - psh[31:0];
                end
                default: begin
                    mag_reg <= rnd[30:10];
                    neg_reg <= half_reg && (rnd[30:10] != 21'd0);
                end
            endcase
        end
    end

    assign done = done_reg;
    assign mag  = mag_reg;
    assign neg  = neg_reg;

endmodule

### src/lrg_secmem.sv
// Sector minimum store: synchronous memory with registered read and
// per-entry valid flags that clear at once. Depends on nothing.
module lrg_secmem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 20
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    output logic          rd_valid,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          clear_all
);
    logic [DW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] valid_reg, valid_next;
    logic [DW-1:0]    rd_data_reg;
    logic             rd_valid_reg;

    always_comb begin
        valid_next = valid_reg;
        if (clear_all) begin
            valid_next = '0;
        end else if (wr_en) begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

### test/tb_lidar_return_gate_sector_min.sv
`timescale 1ns / 100ps
// Self-checking testbench for lidar_return_gate_sector_min: drives returns and frame ends,
// predicts points and sector reports in a scoreboard class and compares every transaction.
// Depends on lrg_pkg and the lidar_return_gate_sector_min RTL.

class sector_scoreboard;
    logic [19:0] min_r, max_r;
    logic        filt;
    logic [4:0]  nsec;
    logic [19:0] sec_min [16];
    logic        sec_ok  [16];
    logic [19:0] frm_min;
    logic        frm_ok;
    logic [15:0] pts, frames;
    logic [148:0] pending [$];
    int errors;
    int points_out, reports_out;

    function new();
        min_r = 20'(lrg_pkg::MIN_RANGE_RST);
        max_r = 20'(lrg_pkg::MAX_RANGE_RST);
        filt = 1'b1;
        nsec = 5'(lrg_pkg::SECTORS_RST);
        clear_frame();
        frames = 0;
        errors = 0;
        points_out = 0;
        reports_out = 0;
    endfunction

    function void clear_frame();
        for (int i = 0; i < 16; i++) begin
            sec_min[i] = 0;
            sec_ok[i] = 0;
        end
        frm_min = 0;
        frm_ok = 0;
        pts = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] v);
        case (idx)
            lrg_pkg::REG_MIN_RANGE: min_r = v[19:0];
            lrg_pkg::REG_MAX_RANGE: max_r = v[19:0];
            lrg_pkg::REG_FILTER_SELF: filt = v[0];
            lrg_pkg::REG_SECTORS: nsec = v[4:0];
            default: ;
        endcase
    endfunction

    function longint unsigned quarter(longint unsigned t);
        longint unsigned t2, inner, mid, q30;
        t2 = (t * t) >> 18;
        inner = 64'(lrg_pkg::SIN_KB) - ((t2 * 64'(lrg_pkg::SIN_KC)) >> 18);
        mid = 64'(lrg_pkg::SIN_KA) - ((t2 * inner) >> 18);
        q30 = (t * mid) >> 18;
        return (q30 + 512) >> 10;
    endfunction

    function void sin_mag(logic [15:0] ph, output longint unsigned mag, output bit neg);
        longint unsigned t;
        t = longint'(ph[13:0]) << 4;
        if (ph[14]) t = (64'd1 << 18) - t;
        mag = quarter(t);
        neg = ph[15] && mag != 0;
    endfunction

    function longint unsigned mulq(longint unsigned a, longint unsigned b);
        return (a * b + (64'd1 << 19)) >> 20;
    endfunction

    function logic [20:0] clamp_out(longint unsigned m, bit neg);
        if (neg) begin
            if (m > (64'd1 << 20)) m = 64'd1 << 20;
            return 21'(-m);
        end
        if (m > (64'd1 << 20) - 1) m = (64'd1 << 20) - 1;
        return 21'(m);
    endfunction

    // Result layout: {last, kind, tdata[146:0]}, tdata padding above bit 140.
    function logic [148:0] pack(logic lst, logic knd, logic [20:0] x, y, z, logic [3:0] si,
                                logic [19:0] sm, logic ss, logic [19:0] fm, logic fs,
                                logic [15:0] pc, logic [15:0] fn);
        return {lst, knd, 6'b000000, fn, pc, fs, fm, ss, sm, si, z, y, x};
    endfunction

    function void note_input(logic eof, logic [15:0] az, logic [15:0] el,
                             logic [19:0] r, logic hit, logic self_hit);
        int n, reps, s;
        longint unsigned ce, se, ca, sa, fx, fy;
        bit nce, nse, nca, nsa;
        n = (nsec > 16) ? 16 : nsec;
        if (eof) begin
            reps = (n == 0) ? 1 : n;
            frames++;
            for (int k = 0; k < reps; k++)
                pending.insert(pending.size(), pack(k == reps - 1, 1'b1,
                    21'd0, 21'd0, 21'd0,
                    (n != 0) ? 4'(k) : 4'd0,
                    (n != 0 && sec_ok[k]) ? sec_min[k] : 20'd0,
                    (n != 0) ? sec_ok[k] : 1'b0,
                    frm_ok ? frm_min : 20'd0, frm_ok, pts, frames));
            clear_frame();
            return;
        end
        if (!hit || (filt && self_hit) || r < min_r || r > max_r) return;
        sin_mag(el + 16'h4000, ce, nce);
        sin_mag(el, se, nse);
        sin_mag(az + 16'h4000, ca, nca);
        sin_mag(az, sa, nsa);
        fx = mulq(ce, ca);
        fy = mulq(ce, sa);
        pending.insert(pending.size(), pack(1'b0, 1'b0,
            clamp_out(mulq(r, fx), nce != nca),
            clamp_out(mulq(r, fy), nce != nsa), clamp_out(mulq(r, se), nse),
            4'd0, 20'd0, 1'b0, 20'd0, 1'b0, 16'd0, 16'd0));
        if (pts != 16'hFFFF) pts++;
        if (!frm_ok || r < frm_min) begin
            frm_min = r;
            frm_ok = 1;
        end
        if (n != 0) begin
            s = (int'(az) * n) >> 16;
            if (s > n - 1) s = n - 1;
            if (!sec_ok[s] || r < sec_min[s]) begin
                sec_min[s] = r;
                sec_ok[s] = 1;
            end
        end
    endfunction

    function void report(string what, logic [148:0] got, logic [148:0] want);
        errors++;
        $display("mismatch: %s got %h want %h", what, got, want);
    endfunction

    function void check_result(logic [148:0] got);
        logic [148:0] want;
        if (pending.size() == 0) begin
            report("unexpected transaction", got, '0);
            return;
        end
        want = pending.pop_front();
        if (got[147]) reports_out++; else points_out++;
        if (got[148] !== want[148]) report("last", got, want);
        if (got[147] !== want[147]) report("kind", got, want);
        if (got[20:0] !== want[20:0]) report("pos_x", got, want);
        if (got[41:21] !== want[41:21]) report("pos_y", got, want);
        if (got[62:42] !== want[62:42]) report("pos_z", got, want);
        if (got[66:63] !== want[66:63]) report("sector_index", got, want);
        if (got[86:67] !== want[86:67]) report("sector_min", got, want);
        if (got[87] !== want[87]) report("sector_seen", got, want);
        if (got[107:88] !== want[107:88]) report("frame_min", got, want);
        if (got[108] !== want[108]) report("frame_seen", got, want);
        if (got[124:109] !== want[124:109]) report("point_count", got, want);
        if (got[140:125] !== want[140:125]) report("frame_number", got, want);
        if (got[146:141] !== 0) report("padding", got, want);
    endfunction
endclass

module tb_lidar_return_gate_sector_min;
    import lrg_pkg::*;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [55:0] s_tdata = 0;
    logic s_tuser = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [143:0] m_tdata;
    logic m_tuser, m_tlast;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [3:0] paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic pready;

    sector_scoreboard sb;
    int cycles = 0;
    int sink_quiet = 0;
    int items_sent = 0;

    always #1 aclk = ~aclk;

    lidar_return_gate_sector_min dut (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver side: check on handshake, then choose the next ready.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result({m_tlast, m_tuser, 3'b000, m_tdata[143:0]});
        m_tready <= (sink_quiet > 0) ? 1'b1 : ($urandom_range(99) >= 33);
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.set_reg(idx, v);
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic wait_empty();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    task automatic send(logic eof, logic [15:0] az, logic [15:0] el, logic [19:0] r,
                        logic hit, logic self_hit, bit gaps);
        while (gaps && $urandom_range(99) < 33) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= eof;
        s_tdata <= {2'b00, self_hit, hit, r, el, az};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(eof, az, el, r, hit, self_hit);
        items_sent++;
    endtask

    task automatic random_frame(int pts, bit gaps);
        logic [19:0] r;
        for (int i = 0; i < pts; i++) begin
            case ($urandom_range(9))
                0: r = 20'($urandom);
                1: r = 20'($urandom_range(120));
                default: r = 20'($urandom_range(sb.max_r + 50,
                                                sb.min_r > 50 ? sb.min_r - 50 : 0));
            endcase
            send(1'b0, 16'($urandom), 16'($urandom), r, $urandom_range(9) != 0,
                 $urandom_range(5) == 0, gaps);
        end
        send(1'b1, 16'($urandom), 16'($urandom), 20'($urandom), 1'($urandom),
             1'($urandom), gaps);
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: field extremes, every quadrant boundary, misses and self hits.
        send(1'b0, 16'h0000, 16'h0000, 20'd1000, 1'b1, 1'b0, 1'b0);
        send(1'b0, 16'h4000, 16'h0000, 20'd40000, 1'b1, 1'b0, 1'b0);
        send(1'b0, 16'h8000, 16'h4000, 20'd100, 1'b1, 1'b0, 1'b0);
        send(1'b0, 16'hC000, 16'hC000, 20'd5000, 1'b1, 1'b0, 1'b0);
        send(1'b0, 16'hFFFF, 16'h8000, 20'd2000, 1'b1, 1'b0, 1'b0);
        send(1'b0, 16'h2000, 16'h7FFF, 20'd3000, 1'b1, 1'b0, 1'b0);
        send(1'b0, 16'h1234, 16'h0100, 20'd99, 1'b1, 1'b0, 1'b0);
        send(1'b0, 16'h1234, 16'h0100, 20'd40001, 1'b1, 1'b0, 1'b0);
        send(1'b0, 16'h1234, 16'h0100, 20'd500, 1'b0, 1'b0, 1'b0);
        send(1'b0, 16'h1234, 16'h0100, 20'd500, 1'b1, 1'b1, 1'b0);
        send(1'b1, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 1'b1, 1'b1, 1'b0);
        send(1'b1, 16'd0, 16'd0, 20'd0, 1'b0, 1'b0, 1'b0);
        drain();
        write_reg(REG_MIN_RANGE, 32'd0);
        write_reg(REG_MAX_RANGE, 32'hFFFFF);
        write_reg(REG_FILTER_SELF, 32'd0);
        write_reg(REG_SECTORS, 32'd31);
        send(1'b0, 16'h5555, 16'h2AAA, 20'hFFFFF, 1'b1, 1'b1, 1'b0);
        send(1'b0, 16'hFFFF, 16'h0000, 20'hFFFFF, 1'b1, 1'b0, 1'b0);
        send(1'b0, 16'h8000, 16'h0000, 20'hFFFFF, 1'b1, 1'b0, 1'b0);
        send(1'b0, 16'hAAAA, 16'hD555, 20'd0, 1'b1, 1'b0, 1'b0);
        send(1'b1, 16'd0, 16'd0, 20'd0, 1'b0, 1'b0, 1'b0);
        drain();
        write_reg(REG_SECTORS, 32'd0);
        send(1'b0, 16'h7000, 16'h0000, 20'd77, 1'b1, 1'b0, 1'b0);
        send(1'b1, 16'd0, 16'd0, 20'd0, 1'b0, 1'b0, 1'b0);
        drain();
        write_reg(REG_MIN_RANGE, 32'd5000);
        write_reg(REG_MAX_RANGE, 32'd4000);
        send(1'b0, 16'h7000, 16'h0000, 20'd4500, 1'b1, 1'b0, 1'b0);
        send(1'b1, 16'd0, 16'd0, 20'd0, 1'b0, 1'b0, 1'b0);
        drain();

        // Random frames over several register settings.
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_MIN_RANGE, $urandom_range(300));
            write_reg(REG_MAX_RANGE, (ph == 5) ? 32'hFFFFF : $urandom_range(900000, 1000));
            write_reg(REG_FILTER_SELF, $urandom_range(1));
            write_reg(REG_SECTORS, (ph == 0) ? 1 : (ph == 1) ? 16 : $urandom_range(20));
            sink_quiet = (ph == 2);
            for (int f = 0; f < 3; f++) begin
                random_frame($urandom_range(34, 8), ph != 2);
                if (f == 1)
                    wait_empty();
            end
            // A sector count change in the middle of a frame.
            if (ph == 3) begin
                send(1'b0, 16'hF000, 16'h0, 20'd900, 1'b1, 1'b0, 1'b1);
                drain();
                write_reg(REG_SECTORS, 32'd3);
                random_frame(10, 1'b1);
            end
            drain();
        end
        sink_quiet = 0;
        drain();

        $display("sent %0d items; checked %0d points and %0d sector reports",
                 items_sent, sb.points_out, sb.reports_out);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
